// ===== rtl/core/hlru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlru_pkg: shared types and constants of the hashed LRU buffer cache
// Entry record layout, operation and status codes, bucket helpers.
// ----------------------------------------------------------------------------
package hlru_pkg;

	localparam int ENTRIES = 32;
	localparam int NBUCKET = 13;
	localparam int IDX_W   = 5;
	localparam int BKT_W   = 4;
	localparam int RANK_W  = 5;
	localparam int CNT_W   = 8;
	localparam int SCNT_W  = 6;
	localparam int RECIP   = 4096 / NBUCKET;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	localparam logic [1:0] OP_GET     = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_PIN     = 2'd2;
	localparam logic [1:0] OP_UNPIN   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_UNDER  = 2'd2;
	localparam logic [1:0] ST_OVER   = 2'd3;

	typedef struct packed {
		logic [7:0]        dev;
		logic [31:0]       blk;
		logic              valid;
		logic [CNT_W-1:0]  cnt;
		logic [BKT_W-1:0]  bkt;
		logic [RANK_W-1:0] rank;
	} entry_t;

	// One radix-16 step of a remainder by the bucket count.
	function automatic logic [BKT_W-1:0] mod_step(logic [BKT_W-1:0] r, logic [3:0] n);
		logic [7:0]  v;
		logic [20:0] prod;
		logic [7:0]  q;
		logic [11:0] qn;
		logic [7:0]  rem;
		v    = {r, n};
		prod = 21'(v) * 21'(RECIP);
		q    = prod[19:12];
		qn   = 12'(q) * 12'(NBUCKET);
		rem  = v - qn[7:0];
		if (rem >= 8'(NBUCKET)) begin
			rem = rem - 8'(NBUCKET);
		end
		return rem[BKT_W-1:0];
	endfunction

	// Reset record of entry k: contiguous bucket ranges, highest index most recent.
	function automatic entry_t init_entry(logic [IDX_W-1:0] k);
		entry_t e;
		int     lo;
		int     hi;
		e = '0;
		for (int i = 0; i < NBUCKET; i++) begin
			lo = (ENTRIES * i) / NBUCKET;
			hi = (ENTRIES * (i + 1)) / NBUCKET;
			if (int'(k) >= lo && int'(k) < hi) begin
				e.bkt  = BKT_W'(i);
				e.rank = RANK_W'(hi - 1 - int'(k));
			end
		end
		return e;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hlru_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlru_hash: iterative block-number to bucket hash
// Reduces a 32-bit value modulo the bucket count, one nibble per cycle.
// ----------------------------------------------------------------------------
module hlru_hash (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [31:0]               value,
	output logic                           done,
	output logic [hlru_pkg::BKT_W-1:0]     rem
);

	logic        run_q;
	logic [2:0]  step_q;
	logic [31:0] val_q;
	logic [hlru_pkg::BKT_W-1:0] r_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (step_q == 3'd7);
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			val_q <= value;
			r_q   <= '0;
		end else if (run_q) begin
			r_q   <= hlru_pkg::mod_step(r_q, val_q[31:28]);
			val_q <= {val_q[27:0], 4'd0};
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule
`default_nettype wire

// ===== rtl/core/hashed_lru_buffer_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache_unit: buffer-cache tag store with hashed LRU buckets
// All entry state lives in one synchronous single-read memory, swept by a
// sequencer for lookup, victim choice and recency relinking.
// ----------------------------------------------------------------------------
// Sequence: get hashes the block number, scans all entries and decides, plus a
//   relink sweep when an entry is stolen from another bucket; release, pin and
//   unpin read the entry, and a release to zero count also hashes and sweeps.
// Throughput: one request at a time; the memory sweep sets the rate.
// Reset: a pass over every entry writes the initial bucket layout, busy stays high.
// The receiver cannot stall: done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module hashed_lru_buffer_cache_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   op,
	input  wire logic [7:0]                   device,
	input  wire logic [31:0]                  block_number,
	input  wire logic [hlru_pkg::IDX_W-1:0]   entry_index,
	output logic                              done,
	output logic [hlru_pkg::IDX_W-1:0]        result_entry,
	output logic                              hit,
	output logic                              need_fill,
	output logic [1:0]                        status
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HASH   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_RDENT  = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_SWEEP  = 3'd6;

	localparam logic [hlru_pkg::SCNT_W-1:0] CNT_END = hlru_pkg::SCNT_W'(hlru_pkg::ENTRIES);

	// Entry memory
	hlru_pkg::entry_t mem [hlru_pkg::ENTRIES];
	hlru_pkg::entry_t rd_data;
	logic [hlru_pkg::IDX_W-1:0] rd_addr;
	logic                       mem_we;
	logic [hlru_pkg::IDX_W-1:0] mem_wa;
	hlru_pkg::entry_t           mem_wd;

	logic [2:0] state_q;
	logic [hlru_pkg::SCNT_W-1:0] cnt_q;
	logic                        vld_s1;
	logic [hlru_pkg::IDX_W-1:0]  addr_s1;

	// Latched request
	logic [1:0]                 op_q;
	logic [7:0]                 dev_q;
	logic [31:0]                blk_q;
	logic [hlru_pkg::IDX_W-1:0] idx_q;
	logic [hlru_pkg::BKT_W-1:0] bkt_q;

	// Scan candidates
	logic                       found_v_q, own_v_q, st_v_q;
	logic [hlru_pkg::IDX_W-1:0] found_idx_q, own_idx_q, st_idx_q;
	hlru_pkg::entry_t           found_rec_q, own_rec_q, st_rec_q;

	// Relink sweep parameters
	logic [hlru_pkg::IDX_W-1:0]  e_idx_q;
	logic [hlru_pkg::BKT_W-1:0]  old_b_q;
	logic [hlru_pkg::RANK_W-1:0] old_r_q;
	hlru_pkg::entry_t            new_rec_q;

	// Result registers
	logic                       done_q, hit_q, fill_q;
	logic [hlru_pkg::IDX_W-1:0] res_entry_q;
	logic [1:0]                 status_q;

	// Hash unit
	logic                       hash_go;
	logic [31:0]                hash_val;
	logic                       hash_done;
	logic [hlru_pkg::BKT_W-1:0] hash_rem;

	logic accept;
	hlru_pkg::entry_t sw_rec;
	logic [hlru_pkg::RANK_W-1:0] sw_r1;
	logic rd_zero_rel;

	assign accept = start && (state_q == S_IDLE);

	// Release that drops the count to zero must relink the entry.
	assign rd_zero_rel = (op_q == hlru_pkg::OP_RELEASE) && (rd_data.cnt == 8'd1);

	assign hash_go  = (accept && (op == hlru_pkg::OP_GET)) ||
	                  ((state_q == S_RDENT) && rd_zero_rel);
	assign hash_val = (state_q == S_IDLE) ? block_number : rd_data.blk;

	hlru_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (hash_go),
		.value  (hash_val),
		.done   (hash_done),
		.rem    (hash_rem)
	);

	// Read the requested entry while idle, otherwise follow the sweep counter.
	assign rd_addr = (state_q == S_IDLE) ? entry_index : cnt_q[hlru_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data <= mem[rd_addr];
	end

	// Unlink from the old bucket, then push every member of the new bucket back.
	always_comb begin
		sw_rec = rd_data;
		sw_r1  = rd_data.rank;
		if (rd_data.bkt == old_b_q && rd_data.rank > old_r_q) begin
			sw_r1 = rd_data.rank - 1'b1;
		end
		if (rd_data.bkt == new_rec_q.bkt) begin
			sw_rec.rank = sw_r1 + 1'b1;
		end else begin
			sw_rec.rank = sw_r1;
		end
	end

	// Memory write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[hlru_pkg::IDX_W-1:0];
		mem_wd = rd_data;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wd = hlru_pkg::init_entry(cnt_q[hlru_pkg::IDX_W-1:0]);
			end
			S_SWEEP: begin
				mem_we = vld_s1;
				mem_wa = addr_s1;
				mem_wd = (addr_s1 == e_idx_q) ? new_rec_q : sw_rec;
			end
			S_DECIDE: begin
				if (found_v_q) begin
					mem_we       = (found_rec_q.cnt != hlru_pkg::CNT_MAX);
					mem_wa       = found_idx_q;
					mem_wd       = found_rec_q;
					mem_wd.cnt   = found_rec_q.cnt + 8'd1;
					mem_wd.valid = 1'b1;
				end else if (own_v_q) begin
					mem_we       = 1'b1;
					mem_wa       = own_idx_q;
					mem_wd       = own_rec_q;
					mem_wd.dev   = dev_q;
					mem_wd.blk   = blk_q;
					mem_wd.valid = 1'b1;
					mem_wd.cnt   = 8'd1;
				end
			end
			S_RDENT: begin
				mem_wa = idx_q;
				if (op_q == hlru_pkg::OP_PIN) begin
					mem_we     = (rd_data.cnt != hlru_pkg::CNT_MAX);
					mem_wd.cnt = rd_data.cnt + 8'd1;
				end else begin
					mem_we     = (rd_data.cnt != 8'd0) && !rd_zero_rel;
					mem_wd.cnt = rd_data.cnt - 8'd1;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					// walk the memory once with the reset layout
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_END - 1'b1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= (op == hlru_pkg::OP_GET) ? S_HASH : S_RDENT;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						cnt_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= (op_q == hlru_pkg::OP_GET) ? S_SCAN : S_SWEEP;
					end
				end
				S_SCAN, S_SWEEP: begin
					// advance the read pointer, one entry per cycle
					if (cnt_q != CNT_END) begin
						vld_s1 <= 1'b1;
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						vld_s1  <= 1'b0;
						if (state_q == S_SCAN) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_RDENT: begin
					if (rd_data.cnt != 8'd0 && rd_zero_rel) begin
						state_q <= S_HASH;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_DECIDE: begin
					if (!found_v_q && !own_v_q && st_v_q) begin
						cnt_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[hlru_pkg::IDX_W-1:0];
		if (accept) begin
			op_q  <= op;
			dev_q <= device;
			blk_q <= block_number;
			idx_q <= entry_index;
		end
		if (state_q == S_HASH && hash_done) begin
			bkt_q         <= hash_rem;
			new_rec_q.bkt <= hash_rem;
			found_v_q     <= 1'b0;
			own_v_q       <= 1'b0;
			st_v_q        <= 1'b0;
		end
		// Scan: most recent match, own-bucket LRU free, lowest other bucket's LRU free
		if (state_q == S_SCAN && vld_s1) begin
			if (rd_data.bkt == bkt_q && rd_data.dev == dev_q && rd_data.blk == blk_q &&
			    (!found_v_q || rd_data.rank < found_rec_q.rank)) begin
				found_v_q   <= 1'b1;
				found_idx_q <= addr_s1;
				found_rec_q <= rd_data;
			end
			if (rd_data.bkt == bkt_q && rd_data.cnt == 8'd0 &&
			    (!own_v_q || rd_data.rank > own_rec_q.rank)) begin
				own_v_q   <= 1'b1;
				own_idx_q <= addr_s1;
				own_rec_q <= rd_data;
			end
			if (rd_data.bkt != bkt_q && rd_data.cnt == 8'd0 &&
			    (!st_v_q || rd_data.bkt < st_rec_q.bkt ||
			     (rd_data.bkt == st_rec_q.bkt && rd_data.rank > st_rec_q.rank))) begin
				st_v_q   <= 1'b1;
				st_idx_q <= addr_s1;
				st_rec_q <= rd_data;
			end
		end
		if (state_q == S_DECIDE) begin
			hit_q       <= 1'b0;
			fill_q      <= 1'b0;
			res_entry_q <= '0;
			status_q    <= hlru_pkg::ST_OK;
			if (found_v_q) begin
				hit_q       <= 1'b1;
				res_entry_q <= found_idx_q;
				if (found_rec_q.cnt == hlru_pkg::CNT_MAX) begin
					status_q <= hlru_pkg::ST_OVER;
				end else begin
					fill_q <= !found_rec_q.valid;
				end
			end else if (own_v_q) begin
				res_entry_q <= own_idx_q;
				fill_q      <= 1'b1;
			end else if (st_v_q) begin
				// steal: relink the victim as most recent of the home bucket
				res_entry_q     <= st_idx_q;
				fill_q          <= 1'b1;
				e_idx_q         <= st_idx_q;
				old_b_q         <= st_rec_q.bkt;
				old_r_q         <= st_rec_q.rank;
				new_rec_q.dev   <= dev_q;
				new_rec_q.blk   <= blk_q;
				new_rec_q.valid <= 1'b1;
				new_rec_q.cnt   <= 8'd1;
				new_rec_q.bkt   <= bkt_q;
				new_rec_q.rank  <= '0;
			end else begin
				status_q <= hlru_pkg::ST_NOFREE;
			end
		end
		if (state_q == S_RDENT) begin
			hit_q       <= 1'b0;
			fill_q      <= 1'b0;
			res_entry_q <= idx_q;
			status_q    <= hlru_pkg::ST_OK;
			if (op_q == hlru_pkg::OP_PIN) begin
				if (rd_data.cnt == hlru_pkg::CNT_MAX) begin
					status_q <= hlru_pkg::ST_OVER;
				end
			end else if (rd_data.cnt == 8'd0) begin
				status_q <= hlru_pkg::ST_UNDER;
			end
			// hold the record for the relink; the new bucket lands after hashing
			e_idx_q         <= idx_q;
			old_b_q         <= rd_data.bkt;
			old_r_q         <= rd_data.rank;
			new_rec_q.dev   <= rd_data.dev;
			new_rec_q.blk   <= rd_data.blk;
			new_rec_q.valid <= rd_data.valid;
			new_rec_q.cnt   <= '0;
			new_rec_q.rank  <= '0;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign result_entry = res_entry_q;
	assign hit          = hit_q;
	assign need_fill    = fill_q;
	assign status       = status_q;

	// Results are only presented on the return to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	// An accepted request always leaves idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted request did not start");

	// Hits come only from get.
	a_hit_get: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && hit_q) |-> op_q == hlru_pkg::OP_GET)
		else $error("hit on non-get request");

	// A fill is only requested on success.
	a_fill_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && fill_q) |-> status_q == hlru_pkg::ST_OK)
		else $error("need_fill with error status");

	// No memory write while idle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q != S_IDLE)
		else $error("memory write while idle");

endmodule
`default_nettype wire

// ===== tb/tb_hashed_lru_buffer_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_lru_buffer_cache_unit: self-checking bench of the hashed LRU cache
// Drives get, release, pin and unpin requests through the start/busy
// handshake, keeps a shadow copy of the bucketed tag store to predict every
// result, and checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hashed_lru_buffer_cache_unit;
	import hlru_pkg::*;

	typedef struct {
		logic [IDX_W-1:0] entry;
		logic             hit;
		logic             fill;
		logic [1:0]       st;
	} cache_result_t;

	// Shadow of the tag store plus the queue of predicted results.
	class cache_scoreboard;
		logic [7:0]       dev_tag [ENTRIES];
		logic [31:0]      blk_tag [ENTRIES];
		logic             valid   [ENTRIES];
		logic [CNT_W-1:0] cnt     [ENTRIES];
		int               bkt     [ENTRIES];
		int               rank    [ENTRIES];
		cache_result_t    pending [$];
		int               failures;

		function new();
			int lo;
			int hi;
			failures = 0;
			for (int i = 0; i < NBUCKET; i++) begin
				lo = (ENTRIES * i) / NBUCKET;
				hi = (ENTRIES * (i + 1)) / NBUCKET;
				for (int k = lo; k < hi; k++) begin
					bkt[k]  = i;
					rank[k] = hi - 1 - k;
				end
			end
			for (int k = 0; k < ENTRIES; k++) begin
				dev_tag[k] = '0;
				blk_tag[k] = '0;
				valid[k]   = 1'b0;
				cnt[k]     = '0;
			end
		endfunction

		function void unlink(int e);
			for (int j = 0; j < ENTRIES; j++)
				if (j != e && bkt[j] == bkt[e] && rank[j] > rank[e])
					rank[j]--;
		endfunction

		function void to_front(int e, int b);
			for (int j = 0; j < ENTRIES; j++)
				if (j != e && bkt[j] == b)
					rank[j]++;
			bkt[e]  = b;
			rank[e] = 0;
		endfunction

		// Least recent idle entry of bucket b, or -1.
		function int oldest_free(int b);
			int best;
			best = -1;
			for (int j = 0; j < ENTRIES; j++)
				if (bkt[j] == b && cnt[j] == 0 && (best < 0 || rank[j] > rank[best]))
					best = j;
			return best;
		endfunction

		function void note_request(logic [1:0] op, logic [7:0] dev, logic [31:0] blk,
				logic [IDX_W-1:0] idx);
			cache_result_t r;
			int            b;
			int            found;
			int            e;
			r = '{entry: '0, hit: 1'b0, fill: 1'b0, st: ST_OK};
			if (op == OP_GET) begin
				b     = int'(blk % NBUCKET);
				found = -1;
				for (int j = 0; j < ENTRIES; j++)
					if (bkt[j] == b && dev_tag[j] == dev && blk_tag[j] == blk &&
							(found < 0 || rank[j] < rank[found]))
						found = j;
				if (found >= 0) begin
					r.entry = IDX_W'(found);
					r.hit   = 1'b1;
					if (cnt[found] == CNT_MAX) begin
						r.st = ST_OVER;
					end else begin
						cnt[found]++;
						r.fill       = !valid[found];
						valid[found] = 1'b1;
					end
				end else begin
					e = oldest_free(b);
					if (e < 0) begin
						// steal from the other buckets in ascending order
						for (int i = 0; i < NBUCKET && e < 0; i++)
							if (i != b)
								e = oldest_free(i);
						if (e >= 0) begin
							unlink(e);
							to_front(e, b);
						end
					end
					if (e < 0) begin
						r.st = ST_NOFREE;
					end else begin
						r.entry    = IDX_W'(e);
						dev_tag[e] = dev;
						blk_tag[e] = blk;
						cnt[e]     = 1;
						r.fill     = 1'b1;
						valid[e]   = 1'b1;
					end
				end
			end else begin
				r.entry = idx;
				if (int'(idx) >= ENTRIES) begin
					r.st = ST_NOFREE;
				end else if (op == OP_PIN) begin
					if (cnt[idx] == CNT_MAX)
						r.st = ST_OVER;
					else
						cnt[idx]++;
				end else if (cnt[idx] == 0) begin
					r.st = ST_UNDER;
				end else begin
					cnt[idx]--;
					if (op == OP_RELEASE && cnt[idx] == 0) begin
						unlink(idx);
						to_front(idx, int'(blk_tag[idx] % NBUCKET));
					end
				end
			end
			pending.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			failures++;
		endtask

		task check_result(logic [IDX_W-1:0] entry, logic hit, logic fill, logic [1:0] st);
			cache_result_t x;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf("unexpected result entry=%0d", entry));
			end else begin
				x = pending.pop_front();
				if (entry !== x.entry)
					flag_mismatch($sformatf("result_entry %0d, want %0d", entry, x.entry));
				if (hit !== x.hit)
					flag_mismatch($sformatf("hit %0b, want %0b", hit, x.hit));
				if (fill !== x.fill)
					flag_mismatch($sformatf("need_fill %0b, want %0b", fill, x.fill));
				if (st !== x.st)
					flag_mismatch($sformatf("status %0d, want %0d", st, x.st));
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       op;
	logic [7:0]       device;
	logic [31:0]      block_number;
	logic [IDX_W-1:0] entry_index;
	logic             done;
	logic [IDX_W-1:0] result_entry;
	logic             hit;
	logic             need_fill;
	logic [1:0]       status;

	cache_scoreboard sb;
	bit              no_idle;
	logic [31:0]     blk_pool [24];
	logic [7:0]      dev_pool [4];

	hashed_lru_buffer_cache_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .device(device), .block_number(block_number), .entry_index(entry_index),
		.done(done), .result_entry(result_entry), .hit(hit), .need_fill(need_fill),
		.status(status)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Check every strobed result; values are read before this edge updates them.
	always @(posedge clk) begin
		if (arst_n && done && sb != null)
			sb.check_result(result_entry, hit, need_fill, status);
	end

	// Present one request, hold it until accepted, then idle a random while unless no_idle is set.
	task issue_request(logic [1:0] r_op, logic [7:0] r_dev, logic [31:0] r_blk,
			logic [IDX_W-1:0] r_idx);
		int gap;
		start        <= 1'b1;
		op           <= r_op;
		device       <= r_dev;
		block_number <= r_blk;
		entry_index  <= r_idx;
		do @(posedge clk); while (busy);
		sb.note_request(r_op, r_dev, r_blk, r_idx);
		gap = no_idle ? 0 : $urandom_range(0, 19);
		// with no gap, keep start high straight into the next request
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pick an entry currently held, falling back to any entry.
	function automatic logic [IDX_W-1:0] held_entry();
		int k;
		for (int t = 0; t < 8; t++) begin
			k = $urandom_range(0, ENTRIES - 1);
			if (sb.cnt[k] != 0)
				return IDX_W'(k);
		end
		for (int j = 0; j < ENTRIES; j++)
			if (sb.cnt[j] != 0)
				return IDX_W'(j);
		return IDX_W'($urandom_range(0, ENTRIES - 1));
	endfunction

	task random_request(bit get_heavy);
		int          roll;
		logic [31:0] blk;
		logic [7:0]  dev;
		roll = $urandom_range(0, 99);
		blk  = blk_pool[$urandom_range(0, 23)];
		dev  = dev_pool[$urandom_range(0, 3)];
		if (roll < (get_heavy ? 55 : 30))
			issue_request(OP_GET, dev, blk, IDX_W'($urandom));
		else if (roll < 80)
			issue_request(OP_RELEASE, 8'($urandom), 32'($urandom), held_entry());
		else if (roll < 86)
			issue_request(OP_PIN, 8'($urandom), 32'($urandom), held_entry());
		else if (roll < 92)
			issue_request(OP_UNPIN, 8'($urandom), 32'($urandom), held_entry());
		else
			issue_request(2'($urandom), 8'($urandom), $urandom, IDX_W'($urandom));
	endtask

	initial begin
		logic [IDX_W-1:0] e;
		sb           = new();
		no_idle      = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_GET;
		device       = '0;
		block_number = '0;
		entry_index  = '0;
		for (int i = 0; i < 24; i++)
			blk_pool[i] = (i < 16) ? 32'(i * 5 + (i % 3)) : $urandom;
		blk_pool[22] = 32'hFFFF_FFFF;
		blk_pool[23] = 32'h8000_000D;
		dev_pool = '{8'h00, 8'h01, 8'hFF, 8'h5A};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset tags match device 0 block 0, extremes, every op.
		issue_request(OP_GET, 8'h00, 32'h0, '0);
		issue_request(OP_GET, 8'h00, 32'h0, '0);
		issue_request(OP_GET, 8'hFF, 32'hFFFF_FFFF, '1);
		issue_request(OP_GET, 8'hFF, 32'hFFFF_FFFF, '0);
		issue_request(OP_RELEASE, 8'h00, 32'h0, 5'd31);
		issue_request(OP_UNPIN, 8'h00, 32'h0, 5'd31);
		issue_request(OP_RELEASE, 8'h00, 32'h0, 5'd31);
		issue_request(OP_PIN, 8'h00, 32'h0, 5'd31);
		issue_request(OP_UNPIN, 8'h00, 32'h0, 5'd31);
		issue_request(OP_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd0);
		issue_request(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
		// same bucket over and over: drain bucket 0, then steal from others
		for (int i = 1; i <= 6; i++)
			issue_request(OP_GET, 8'(i), 32'(13 * i), '0);
		issue_request(OP_GET, 8'h03, 32'd39, '0);
		issue_request(OP_RELEASE, 8'h00, 32'h0, sb.pending.size() > 0 ? 5'd2 : 5'd2);

		// Count saturation: pin one held entry past its limit, hit it, back it off.
		no_idle = 1'b1;
		issue_request(OP_GET, 8'h77, 32'h1234_5678, '0);
		e = sb.pending[$].entry;
		while (sb.cnt[e] != CNT_MAX)
			issue_request(OP_PIN, 8'h00, 32'h0, e);
		issue_request(OP_PIN, 8'h00, 32'h0, e);
		issue_request(OP_GET, 8'h77, 32'h1234_5678, '0);
		issue_request(OP_RELEASE, 8'h00, 32'h0, e);
		issue_request(OP_UNPIN, 8'h00, 32'h0, e);
		no_idle = 1'b0;

		// Random: alternate filling phases (reach no free entry) and draining phases.
		for (int n = 0; n < 220; n++) begin
			if (n % 25 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			random_request((n / 100) % 2 == 0);
		end
		start <= 1'b0;

		// Drain outstanding results, then let any trailing strobe show up.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hlru_pkg.sv
rtl/core/hlru_hash.sv
rtl/core/hashed_lru_buffer_cache_unit.sv
tb/tb_hashed_lru_buffer_cache_unit.sv
